/* rtl/core/cs_pkg.sv */
// ----------------------------------------------------------------------------
// cs_pkg: shared types, constants and a function for the cubic smoothstep core
// The queue entry layout, pipeline stage records and the divider step.
// ----------------------------------------------------------------------------
package cs_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

  // quotient bits of t = (x-a)*2^16/(b-a), one per divider stage
  localparam int TBits  = 16;

  localparam logic [16:0] OneQ16   = 17'h10000;
  localparam logic [17:0] ThreeQ16 = 18'd196608;

  // one classified request waiting for the back end
  typedef struct packed {
    logic        mid;   // a <= x < b: needs the divide and polynomial
    logic        one;   // a <= x and x >= b: saturate to 1.0
    logic [31:0] offs;  // x - a
    logic [31:0] span;  // b - a
  } cs_item_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } cs_q_stat_t;

  // one divider stage's record
  typedef struct packed {
    logic             mid;
    logic             one;
    logic [31:0]      rem;
    logic [31:0]      span;
    logic [TBits-1:0] quot;
  } cs_div_t;

  // restoring division step: returns {quotient bit, new remainder}; rem < span
  function automatic logic [32:0] cs_div_step(input logic [31:0] rem,
                                              input logic [31:0] span);
    logic [32:0] sh;
    logic [33:0] df;
    logic        ge;
    sh = {rem, 1'b0};
    df = {1'b0, sh} - {2'b00, span};
    ge = ~df[33];
    return {ge, (ge ? df[31:0] : sh[31:0])};
  endfunction

endpackage

/* rtl/core/cs_front.sv */
// ----------------------------------------------------------------------------
// cs_front: request intake and classification
// Compares the sample against both edges and forms the differences.
// ----------------------------------------------------------------------------
module cs_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_lower_edge,
  input  logic signed [31:0]    in_upper_edge,
  input  logic signed [31:0]    in_sample,
  input  cs_pkg::cs_q_stat_t    q_stat,
  output logic                  push,
  output cs_pkg::cs_item_t      push_item
);

  logic        below;
  logic        above;
  logic [32:0] dist_w;
  logic [32:0] span_w;

  always_comb begin
    below  = in_sample < in_lower_edge;
    above  = in_sample >= in_upper_edge;
    dist_w = {in_sample[31], in_sample} - {in_lower_edge[31], in_lower_edge};
    span_w = {in_upper_edge[31], in_upper_edge} - {in_lower_edge[31], in_lower_edge};
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // below-lower-edge wins over at-or-above-upper-edge
  always_comb begin
    push_item.mid  = !below && !above;
    push_item.one  = !below && above;
    push_item.offs = dist_w[31:0];
    push_item.span = span_w[31:0];
  end

endmodule

/* rtl/core/cs_fifo.sv */
// ----------------------------------------------------------------------------
// cs_fifo: short request queue between front and back end
// Lets the intake keep taking requests while the back end is held.
// ----------------------------------------------------------------------------
module cs_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  cs_pkg::cs_item_t    wr_item,
  input  logic                rd,
  output cs_pkg::cs_item_t    rd_item,
  output cs_pkg::cs_q_stat_t  stat
);

  cs_pkg::cs_item_t              mem_r [cs_pkg::QDepth];
  logic [cs_pkg::QPtrW-1:0]      wp_r, wp_nxt;
  logic [cs_pkg::QPtrW-1:0]      rp_r, rp_nxt;
  logic [cs_pkg::QCntW-1:0]      cnt_r, cnt_nxt;
  logic                          do_wr;
  logic                          do_rd;

  assign stat.full     = cnt_r == cs_pkg::QCntW'(cs_pkg::QDepth);
  assign stat.nonempty = cnt_r != '0;
  assign rd_item       = mem_r[rp_r];

  always_comb begin
    do_wr   = wr && !stat.full;
    do_rd   = rd && stat.nonempty;
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

/* rtl/core/cs_back.sv */
// ----------------------------------------------------------------------------
// cs_back: divide and Hermite polynomial pipeline
// 16 one-bit divider stages, then t*t and t2*(3-2t), then the output register.
// ----------------------------------------------------------------------------
module cs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cs_pkg::cs_q_stat_t  q_stat,
  input  cs_pkg::cs_item_t    q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [16:0]         out_smooth_value
);

  localparam int TB = cs_pkg::TBits;

  cs_pkg::cs_div_t   div_r   [TB];
  cs_pkg::cs_div_t   div_nxt [TB];
  logic [TB-1:0]     dv_r, dv_nxt;

  logic              m1v_r;
  logic              m1_mid_r;
  logic              m1_one_r;
  logic [TB-1:0]     m1_t_r;
  logic [TB-1:0]     m1_t2_r;
  logic [31:0]       sq;

  logic              out_valid_r;
  logic [16:0]       out_value_r;
  logic [17:0]       k;
  logic [33:0]       poly;
  logic [16:0]       value_nxt;

  logic              en;
  logic [32:0]       st [TB];

  // whole pipeline advances unless a result is held at the output
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_stat.nonempty;

  always_comb begin
    st[0]           = cs_pkg::cs_div_step(q_item.offs, q_item.span);
    dv_nxt[0]       = q_stat.nonempty;
    div_nxt[0].mid  = q_item.mid;
    div_nxt[0].one  = q_item.one;
    div_nxt[0].span = q_item.span;
    div_nxt[0].rem  = st[0][31:0];
    div_nxt[0].quot = {{(TB-1){1'b0}}, st[0][32]};
    for (int i = 1; i < TB; i++) begin
      st[i]           = cs_pkg::cs_div_step(div_r[i-1].rem, div_r[i-1].span);
      dv_nxt[i]       = dv_r[i-1];
      div_nxt[i].mid  = div_r[i-1].mid;
      div_nxt[i].one  = div_r[i-1].one;
      div_nxt[i].span = div_r[i-1].span;
      div_nxt[i].rem  = st[i][31:0];
      div_nxt[i].quot = {div_r[i-1].quot[TB-2:0], st[i][32]};
    end
  end

  always_comb begin
    sq        = {16'b0, div_r[TB-1].quot} * {16'b0, div_r[TB-1].quot};
    k         = cs_pkg::ThreeQ16 - {1'b0, m1_t_r, 1'b0};
    poly      = {18'b0, m1_t2_r} * {16'b0, k};
    value_nxt = m1_mid_r ? poly[32:16] : (m1_one_r ? cs_pkg::OneQ16 : 17'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      m1v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_r        <= dv_nxt;
      m1v_r       <= dv_r[TB-1];
      out_valid_r <= m1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < TB; i++) begin
        div_r[i] <= div_nxt[i];
      end
      m1_mid_r    <= div_r[TB-1].mid;
      m1_one_r    <= div_r[TB-1].one;
      m1_t_r      <= div_r[TB-1].quot;
      m1_t2_r     <= sq[31:16];
      out_value_r <= value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_smooth_value = out_value_r;

endmodule

/* rtl/core/cubic_smoothstep_core.sv */
// ----------------------------------------------------------------------------
// cubic_smoothstep_core: fixed-point cubic smoothstep (3t^2 - 2t^3)
// Takes a lower edge, an upper edge and a sample in signed Q16.16 and returns
// the smoothstep of the sample in unsigned Q1.16, with 65536 meaning 1.0.
// ----------------------------------------------------------------------------
// Throughput is one request per clock while no result is held by out_stall.
// A request passes from the 4-entry request queue through the bit-per-stage
// divider that forms t and the t*t multiplier stage, and then
// t2*(3-2t) is formed into the output register. While a result is held
// by out_stall the back pipeline freezes as a whole; requests keep being
// accepted until the queue fills, then in_stall rises.
module cubic_smoothstep_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_lower_edge,
  input  logic signed [31:0] in_upper_edge,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_smooth_value
);

  cs_pkg::cs_q_stat_t q_stat;
  cs_pkg::cs_item_t   push_item;
  cs_pkg::cs_item_t   head_item;
  logic               push;
  logic               pop;

  cs_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_lower_edge (in_lower_edge),
    .in_upper_edge (in_upper_edge),
    .in_sample     (in_sample),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  cs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (push),
    .wr_item (push_item),
    .rd      (pop),
    .rd_item (head_item),
    .stat    (q_stat)
  );

  cs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_item           (head_item),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_smooth_value (out_smooth_value)
  );

endmodule

/* rtl/core/cs_checker.sv */
// ----------------------------------------------------------------------------
// cs_checker: port-level checks for the cubic smoothstep core
// Watches the top-level ports only; bound to the core below.
// ----------------------------------------------------------------------------
module cs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] in_lower_edge,
  input logic signed [31:0] in_upper_edge,
  input logic signed [31:0] in_sample,
  input logic               out_valid,
  input logic               out_stall,
  input logic [16:0]        out_smooth_value
);

  // result never exceeds 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_smooth_value <= 17'h10000)
    else $error("smooth value above one");

  // pipeline holds nothing right after reset
  a_rst_out: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // queue is empty after reset, so intake is open
  a_rst_in: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_stall)
    else $error("intake stalled right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_smooth_value))
    else $error("stalled result dropped or changed");

endmodule

bind cubic_smoothstep_core cs_checker u_cs_checker (.*);

/* bench/cubic_smoothstep_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_smoothstep_core_tb: regression bench for the cubic smoothstep core
// Feeds edge/sample requests (directed corners, then mostly well-formed random
// ranges) with random gaps and output stalls, predicts each smoothstep value
// in Q1.16 and checks every result in order.
// ----------------------------------------------------------------------------
module cubic_smoothstep_core_tb;

  localparam int NumRandom  = 1850;
  localparam int IdleLimit  = 4000;
  localparam int DrainWait  = 40;
  localparam longint Min32  = -64'sd2147483648;
  localparam longint Max32  = 64'sd2147483647;
  localparam longint Span32 = 64'sd4294967296;

  typedef struct {
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic signed [31:0] sample;
  } smooth_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_lower_edge = '0;
  logic signed [31:0] in_upper_edge = '0;
  logic signed [31:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] out_smooth_value;

  smooth_req_t pending_reqs[$];
  logic [16:0] expected_smooth[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  logic        req_taken = 1'b0;
  logic        quiet = 1'b0;   // stretch with no gaps and no stalls

  cubic_smoothstep_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_lower_edge    (in_lower_edge),
    .in_upper_edge    (in_upper_edge),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_smooth_value (out_smooth_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [16:0] smoothstep_q16(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic signed [31:0] x);
    longint sa;
    longint sb;
    longint sx;
    longint unsigned offs;
    longint unsigned span;
    longint unsigned t;
    longint unsigned t2;
    sa = a;
    sb = b;
    sx = x;
    if (sx < sa) return 17'd0;
    if (sx >= sb) return cs_pkg::OneQ16;
    offs = longint'(sx - sa);
    span = longint'(sb - sa);
    t    = (offs << 16) / span;
    t2   = (t * t) >> 16;
    return 17'((t2 * (longint'(cs_pkg::ThreeQ16) - 2 * t)) >> 16);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint unsigned rand64();
    return longint'({32'd0, $urandom});
  endfunction

  task automatic add_req(input longint a, input longint b, input longint x);
    smooth_req_t r;
    r.lower  = a[31:0];
    r.upper  = b[31:0];
    r.sample = x[31:0];
    pending_reqs.push_back(r);
  endtask

  task automatic add_random_req();
    longint span;
    longint a;
    longint b;
    longint x;
    int     kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // raw noise over the full field range
      add_req(longint'(int'($urandom)), longint'(int'($urandom)), longint'(int'($urandom)));
    end else begin
      span = longint'(rand64() >> $urandom_range(0, 31));
      if (span == 0) span = 1;
      if (span > Span32 - 1) span = Span32 - 1;
      a = Min32 + longint'(rand64() % longint'(Span32 - span));
      b = a + span;
      x = a + longint'(rand64() % longint'(span));
      if (kind < 70) begin
      end else if (kind < 76) begin
        x = a;
      end else if (kind < 82) begin
        x = b - 1;
      end else if (kind < 91) begin
        x = b + longint'(rand64() % longint'(Max32 - b + 1));
      end else if (a > Min32) begin
        x = a - 1 - longint'(rand64() % longint'(a - Min32));
      end
      if ($urandom_range(0, 9) == 0) add_req(b, a, x);   // reversed edges
      else add_req(a, b, x);
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid      <= 1'b1;
        in_lower_edge <= pending_reqs[0].lower;
        in_upper_edge <= pending_reqs[0].upper;
        in_sample     <= pending_reqs[0].sample;
        send_gap      <= quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    end
  end

  // acceptance and checking on the rising edge
  always @(posedge clk) begin
    logic [16:0] want;
    if (rst_n) begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_smooth.push_back(smoothstep_q16(in_lower_edge, in_upper_edge, in_sample));
        void'(pending_reqs.pop_front());
        if ($urandom_range(0, 149) == 0) quiet <= ~quiet;
      end
      if (out_valid && !out_stall) begin
        if (expected_smooth.size() == 0) begin
          $error("out_smooth_value with no request pending: actual %0d", out_smooth_value);
          fail_count++;
        end else begin
          want = expected_smooth.pop_front();
          if (out_smooth_value !== want) begin
            $error("out_smooth_value mismatch: expected %0d, actual %0d",
                   want, out_smooth_value);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("cubic_smoothstep_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    // full-range corners
    add_req(Min32, Max32, Min32);
    add_req(Min32, Max32, Max32);
    add_req(Min32, Max32, Max32 - 1);
    add_req(Min32, Max32, 0);
    add_req(Max32, Min32, 0);
    add_req(Max32, Min32, Max32);
    add_req(Max32, Max32, Min32);
    // equal edges
    add_req(0, 0, 0);
    add_req(0, 0, -1);
    add_req(-1, -1, -1);
    // reversed edges with the sample between and above them
    add_req(5, -5, 0);
    add_req(5, -5, 10);
    // in and around a unit step
    add_req(0, 65536, 0);
    add_req(0, 65536, 32768);
    add_req(0, 65536, 65535);
    add_req(0, 65536, 65536);
    add_req(0, 65536, -1);
    // narrow spans, then two wide spans
    add_req(0, 1, 0);
    add_req(0, 3, 2);
    add_req(-7, -4, -5);
    add_req(Max32 - 1, Max32, Max32 - 1);
    add_req(Min32, Min32 + 1, Min32);
    add_req(32'sh5555_5555, 32'sh7FFF_AAAA, 32'sh6AAA_5555);
    add_req(-64'sh5555_5555, 32'sh2AAA_AAAA, 32'sh1234_5678);
    repeat (NumRandom) add_random_req();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0) @(posedge clk);
    while (expected_smooth.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0) begin
      $display("cubic_smoothstep_core regression: pass");
    end else begin
      $display("cubic_smoothstep_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/cs_pkg.sv
rtl/core/cs_front.sv
rtl/core/cs_fifo.sv
rtl/core/cs_back.sv
rtl/core/cubic_smoothstep_core.sv
rtl/core/cs_checker.sv
bench/cubic_smoothstep_core_tb.sv
